### src/gpf_pkg.sv
`default_nettype none

package gpf_pkg;

	// Widths of the number and the datapath registers
	localparam int VALUE_WIDTH = 16;
	localparam int LOW_WIDTH   = VALUE_WIDTH - 1;
	localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 2;
	localparam int SQ_WIDTH    = 2 * DIV_WIDTH;
	localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
	localparam int PC_WIDTH    = 5;

	// Fixed numbers of the search
	localparam logic [VALUE_WIDTH-1:0] VAL_TWO   = VALUE_WIDTH'(2);
	localparam logic [VALUE_WIDTH-1:0] VAL_THREE = VALUE_WIDTH'(3);
	localparam logic [VALUE_WIDTH-1:0] VAL_FOUR  = VALUE_WIDTH'(4);
	localparam logic [LOW_WIDTH-1:0]   LOW_TWO   = LOW_WIDTH'(2);
	localparam logic [DIV_WIDTH-1:0]   DIV_THREE = DIV_WIDTH'(3);
	localparam logic [DIV_WIDTH-1:0]   DIV_TWO   = DIV_WIDTH'(2);
	localparam logic [SQ_WIDTH-1:0]    SQ_NINE   = SQ_WIDTH'(9);
	localparam logic [SQ_WIDTH-1:0]    SQ_FOUR   = SQ_WIDTH'(4);

	// Datapath action of one control word
	typedef enum logic [3:0] {
		ACT_NOP,
		ACT_LOAD,
		ACT_SEL_C,
		ACT_SEL_NC,
		ACT_SET_PAIR,
		ACT_INC_C,
		ACT_INIT_D,
		ACT_START_REM,
		ACT_CHK_REM,
		ACT_INC_D,
		ACT_SET_FOUR,
		ACT_EMIT
	} act_t;

	// Jump condition of one control word
	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_N_EQ4,
		COND_C_GT_HALF,
		COND_PHASE1,
		COND_NOT_OK,
		COND_V_TRIVIAL,
		COND_SQ_GT_V,
		COND_REM_BUSY,
		COND_REM_ZERO,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		act_t                act;
		cond_t               cond;
		logic [PC_WIDTH-1:0] target;
	} ucode_t;

	// Program addresses
	localparam logic [PC_WIDTH-1:0] PC_IDLE     = PC_WIDTH'(0);
	localparam logic [PC_WIDTH-1:0] PC_CHK4     = PC_WIDTH'(1);
	localparam logic [PC_WIDTH-1:0] PC_LOOP     = PC_WIDTH'(2);
	localparam logic [PC_WIDTH-1:0] PC_SEL_C    = PC_WIDTH'(3);
	localparam logic [PC_WIDTH-1:0] PC_RET      = PC_WIDTH'(4);
	localparam logic [PC_WIDTH-1:0] PC_SEL_NC   = PC_WIDTH'(5);
	localparam logic [PC_WIDTH-1:0] PC_GO_TEST  = PC_WIDTH'(6);
	localparam logic [PC_WIDTH-1:0] PC_RET2     = PC_WIDTH'(7);
	localparam logic [PC_WIDTH-1:0] PC_PAIR     = PC_WIDTH'(8);
	localparam logic [PC_WIDTH-1:0] PC_NEXT     = PC_WIDTH'(9);
	localparam logic [PC_WIDTH-1:0] PC_TEST     = PC_WIDTH'(10);
	localparam logic [PC_WIDTH-1:0] PC_DLOOP    = PC_WIDTH'(11);
	localparam logic [PC_WIDTH-1:0] PC_REM_GO   = PC_WIDTH'(12);
	localparam logic [PC_WIDTH-1:0] PC_REM_WAIT = PC_WIDTH'(13);
	localparam logic [PC_WIDTH-1:0] PC_REM_CHK  = PC_WIDTH'(14);
	localparam logic [PC_WIDTH-1:0] PC_INC_D    = PC_WIDTH'(15);
	localparam logic [PC_WIDTH-1:0] PC_FOUR     = PC_WIDTH'(16);
	localparam logic [PC_WIDTH-1:0] PC_EMIT     = PC_WIDTH'(17);
	localparam logic [PC_WIDTH-1:0] PC_BACK     = PC_WIDTH'(18);

	// Control store: the action runs, then jump to target if cond holds, else step on
	function automatic ucode_t gpf_ucode(input logic [PC_WIDTH-1:0] pc);
		ucode_t w;
		w = '{act: ACT_NOP, cond: COND_ALWAYS, target: PC_IDLE};
		case (pc)
			PC_IDLE:     w = '{act: ACT_LOAD,      cond: COND_NO_INPUT,  target: PC_IDLE};
			PC_CHK4:     w = '{act: ACT_NOP,       cond: COND_N_EQ4,     target: PC_FOUR};
			PC_LOOP:     w = '{act: ACT_NOP,       cond: COND_C_GT_HALF, target: PC_EMIT};
			PC_SEL_C:    w = '{act: ACT_SEL_C,     cond: COND_ALWAYS,    target: PC_TEST};
			PC_RET:      w = '{act: ACT_NOP,       cond: COND_PHASE1,    target: PC_RET2};
			PC_SEL_NC:   w = '{act: ACT_SEL_NC,    cond: COND_NOT_OK,    target: PC_NEXT};
			PC_GO_TEST:  w = '{act: ACT_NOP,       cond: COND_ALWAYS,    target: PC_TEST};
			PC_RET2:     w = '{act: ACT_NOP,       cond: COND_NOT_OK,    target: PC_NEXT};
			PC_PAIR:     w = '{act: ACT_SET_PAIR,  cond: COND_ALWAYS,    target: PC_EMIT};
			PC_NEXT:     w = '{act: ACT_INC_C,     cond: COND_ALWAYS,    target: PC_LOOP};
			PC_TEST:     w = '{act: ACT_INIT_D,    cond: COND_V_TRIVIAL, target: PC_RET};
			PC_DLOOP:    w = '{act: ACT_NOP,       cond: COND_SQ_GT_V,   target: PC_RET};
			PC_REM_GO:   w = '{act: ACT_START_REM, cond: COND_NEVER,     target: PC_IDLE};
			PC_REM_WAIT: w = '{act: ACT_NOP,       cond: COND_REM_BUSY,  target: PC_REM_WAIT};
			PC_REM_CHK:  w = '{act: ACT_CHK_REM,   cond: COND_REM_ZERO,  target: PC_RET};
			PC_INC_D:    w = '{act: ACT_INC_D,     cond: COND_ALWAYS,    target: PC_DLOOP};
			PC_FOUR:     w = '{act: ACT_SET_FOUR,  cond: COND_ALWAYS,    target: PC_EMIT};
			PC_EMIT:     w = '{act: ACT_EMIT,      cond: COND_OUT_BUSY,  target: PC_EMIT};
			PC_BACK:     w = '{act: ACT_NOP,       cond: COND_ALWAYS,    target: PC_IDLE};
			default:     w = '{act: ACT_NOP,       cond: COND_ALWAYS,    target: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### src/gpf_div.sv
`default_nettype none

module gpf_div
	import gpf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] dividend,
	input  wire logic [DIV_WIDTH-1:0]   divisor,
	output logic                        busy,
	output logic [DIV_WIDTH-1:0]        rem
);

	logic                   busy_q;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic [VALUE_WIDTH-1:0] dvd_q;
	logic [DIV_WIDTH-1:0]   div_q;
	logic [DIV_WIDTH-1:0]   rem_q;
	logic [DIV_WIDTH:0]     shifted;
	logic [DIV_WIDTH:0]     diff;
	logic [DIV_WIDTH-1:0]   rem_next;

	// Bring in one dividend bit and subtract the divisor where it fits
	always_comb begin
		shifted  = {rem_q, dvd_q[VALUE_WIDTH-1]};
		diff     = shifted - {1'b0, div_q};
		rem_next = diff[DIV_WIDTH] ? shifted[DIV_WIDTH-1:0] : diff[DIV_WIDTH-1:0];
	end

	// Count one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_WIDTH'(VALUE_WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_WIDTH'(1);
			if (cnt_q == CNT_WIDTH'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Hold operands and the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

`ifndef NO_ASSERTIONS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (rem_q < div_q))
		else $error("remainder not below divisor");

	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("remainder unit busy with zero count");

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("remainder unit started while busy");
`endif

endmodule

`default_nettype wire

### src/goldbach_prime_pair_finder.sv
`default_nettype none

// Splits an unsigned number into two primes: 4 gives 2+2, otherwise odd candidates c
// from 3 up to n/2 are tried in rising order and the first c with c and n-c both prime
// is returned, with found set; when none exists the word is 2,2 with found clear.
// Primality is decided by trial division with odd divisors d while d*d <= v; each
// remainder comes from a bit-serial unit, which dominates the run time. One word is
// worked on at a time; the result sits in an output register, so the next word is
// taken while it waits.
module goldbach_prime_pair_finder
	import gpf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire logic [VALUE_WIDTH-1:0] even_value,
	output logic                        res_valid,
	input  wire logic                   res_stall,
	output logic [LOW_WIDTH-1:0]        prime_low,
	output logic [VALUE_WIDTH-1:0]      prime_high,
	output logic                        found
);

	logic [PC_WIDTH-1:0]    pc_q;
	ucode_t                 uw;
	logic                   jump;

	logic [VALUE_WIDTH-1:0] n_q;
	logic [VALUE_WIDTH-1:0] c_q;
	logic [VALUE_WIDTH-1:0] v_q;
	logic [DIV_WIDTH-1:0]   d_q;
	logic [SQ_WIDTH-1:0]    sq_q;
	logic                   ok_q;
	logic                   phase_q;
	logic [LOW_WIDTH-1:0]   res_low_q;
	logic [VALUE_WIDTH-1:0] res_high_q;
	logic                   res_found_q;

	logic                   out_valid_q;
	logic [LOW_WIDTH-1:0]   out_low_q;
	logic [VALUE_WIDTH-1:0] out_high_q;
	logic                   out_found_q;

	logic                   accept;
	logic                   out_busy;
	logic                   write_out;
	logic                   div_start;
	logic                   div_busy;
	logic [DIV_WIDTH-1:0]   div_rem;

	assign uw        = gpf_ucode(pc_q);
	assign accept    = req_valid && (pc_q == PC_IDLE);
	assign out_busy  = out_valid_q && res_stall;
	assign write_out = (uw.act == ACT_EMIT) && !out_busy;
	assign div_start = (uw.act == ACT_START_REM);

	// Evaluate the jump condition of the current control word
	always_comb begin
		case (uw.cond)
			COND_NEVER:     jump = 1'b0;
			COND_ALWAYS:    jump = 1'b1;
			COND_NO_INPUT:  jump = !req_valid;
			COND_N_EQ4:     jump = (n_q == VAL_FOUR);
			COND_C_GT_HALF: jump = (c_q > (n_q >> 1));
			COND_PHASE1:    jump = phase_q;
			COND_NOT_OK:    jump = !ok_q;
			COND_V_TRIVIAL: jump = (v_q < VAL_THREE) || !v_q[0];
			COND_SQ_GT_V:   jump = (sq_q > SQ_WIDTH'(v_q));
			COND_REM_BUSY:  jump = div_busy;
			COND_REM_ZERO:  jump = (div_rem == '0);
			COND_OUT_BUSY:  jump = out_busy;
			default:        jump = 1'b1;
		endcase
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else if (jump) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + PC_WIDTH'(1);
		end
	end

	// Datapath registers driven by the control word
	always_ff @(posedge clk) begin
		case (uw.act)
			ACT_LOAD: begin
				if (accept) begin
					n_q         <= even_value;
					c_q         <= VAL_THREE;
					res_low_q   <= LOW_TWO;
					res_high_q  <= VAL_TWO;
					res_found_q <= 1'b0;
				end
			end
			ACT_SEL_C: begin
				v_q     <= c_q;
				phase_q <= 1'b0;
			end
			ACT_SEL_NC: begin
				v_q     <= n_q - c_q;
				phase_q <= 1'b1;
			end
			ACT_SET_PAIR: begin
				res_low_q   <= c_q[LOW_WIDTH-1:0];
				res_high_q  <= n_q - c_q;
				res_found_q <= 1'b1;
			end
			ACT_INC_C: begin
				c_q <= c_q + VAL_TWO;
			end
			ACT_INIT_D: begin
				d_q  <= DIV_THREE;
				sq_q <= SQ_NINE;
				ok_q <= (v_q == VAL_TWO) || (v_q[0] && (v_q != VALUE_WIDTH'(1)));
			end
			ACT_CHK_REM: begin
				if (div_rem == '0) begin
					ok_q <= 1'b0;
				end
			end
			ACT_INC_D: begin
				d_q  <= d_q + DIV_TWO;
				sq_q <= sq_q + (SQ_WIDTH'(d_q) << 2) + SQ_FOUR;
			end
			ACT_SET_FOUR: begin
				res_low_q   <= LOW_TWO;
				res_high_q  <= VAL_TWO;
				res_found_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Output word register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (write_out) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (write_out) begin
			out_low_q   <= res_low_q;
			out_high_q  <= res_high_q;
			out_found_q <= res_found_q;
		end
	end

	gpf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (v_q),
		.divisor  (d_q),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	assign req_stall  = (pc_q != PC_IDLE);
	assign res_valid  = out_valid_q;
	assign prime_low  = out_low_q;
	assign prime_high = out_high_q;
	assign found      = out_found_q;

`ifndef NO_ASSERTIONS
	a_pair_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(write_out && res_found_q) |-> ((VALUE_WIDTH'(res_low_q) + res_high_q) == n_q))
		else $error("reported pair does not add up to the number");

	a_div_only_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (pc_q == PC_REM_WAIT))
		else $error("remainder unit running outside its wait step");

	a_square_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == PC_DLOOP) |-> (sq_q == (SQ_WIDTH'(d_q) * SQ_WIDTH'(d_q))))
		else $error("divisor square out of step with divisor");
`endif

endmodule

`default_nettype wire

### tb/sv/testbench.sv
module testbench;
	import gpf_pkg::*;

	localparam int HOLD_CYCLES  = 2000;
	localparam int DRAIN_CYCLES = 200;
	localparam int LIMIT_CYCLES = 16_000_000;
	localparam int DIR_ROWS     = 21;

	typedef enum {
		PH_DIRECTED,
		PH_FREE,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH,
		PH_HOLD
	} phase_t;

	// One expected prime pair
	typedef struct packed {
		logic [LOW_WIDTH-1:0]   low;
		logic [VALUE_WIDTH-1:0] high;
		logic                   fnd;
	} pair_t;

	// One number to split, with its pair typed in when it is obvious
	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic                   typed;
		logic [LOW_WIDTH-1:0]   low;
		logic [VALUE_WIDTH-1:0] high;
		logic                   fnd;
	} row_t;

	// Directed rows: tiny values, odd values, the value four, and the field extremes
	localparam row_t DIR_TAB [DIR_ROWS] = '{
		'{16'd0,     1'b1, 15'd2, 16'd2, 1'b0},
		'{16'd1,     1'b1, 15'd2, 16'd2, 1'b0},
		'{16'd2,     1'b1, 15'd2, 16'd2, 1'b0},
		'{16'd3,     1'b1, 15'd2, 16'd2, 1'b0},
		'{16'd4,     1'b1, 15'd2, 16'd2, 1'b1},
		'{16'd5,     1'b1, 15'd2, 16'd2, 1'b0},
		'{16'd6,     1'b1, 15'd3, 16'd3, 1'b1},
		'{16'd7,     1'b1, 15'd2, 16'd2, 1'b0},
		'{16'd8,     1'b1, 15'd3, 16'd5, 1'b1},
		'{16'd10,    1'b1, 15'd3, 16'd7, 1'b1},
		'{16'd9,     1'b1, 15'd2, 16'd2, 1'b0},
		'{16'd12,    1'b0, 15'd0, 16'd0, 1'b0},
		'{16'hFFFE,  1'b0, 15'd0, 16'd0, 1'b0},
		'{16'h8000,  1'b0, 15'd0, 16'd0, 1'b0},
		'{16'h7FFE,  1'b0, 15'd0, 16'd0, 1'b0},
		'{16'hAAAA,  1'b0, 15'd0, 16'd0, 1'b0},
		'{16'h5554,  1'b0, 15'd0, 16'd0, 1'b0},
		'{16'd1023,  1'b1, 15'd2, 16'd2, 1'b0},
		'{16'd257,   1'b1, 15'd2, 16'd2, 1'b0},
		'{16'd100,   1'b0, 15'd0, 16'd0, 1'b0},
		'{16'd98,    1'b0, 15'd0, 16'd0, 1'b0}
	};

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   req_valid  = 1'b0;
	logic                   req_stall;
	logic [VALUE_WIDTH-1:0] even_value = '0;
	logic                   res_valid;
	logic                   res_stall  = 1'b0;
	logic [LOW_WIDTH-1:0]   prime_low;
	logic [VALUE_WIDTH-1:0] prime_high;
	logic                   found;

	phase_t phase = PH_DIRECTED;
	row_t   numbers_q [$];
	pair_t  pending_pairs [$];
	row_t   offered;
	pair_t  want;
	int     fails     = 0;
	int     words_out = 0;
	int     cycles    = 0;
	int     hold_cnt  = 0;
	bit     hold_done = 1'b0;

	goldbach_prime_pair_finder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.even_value (even_value),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.prime_low  (prime_low),
		.prime_high (prime_high),
		.found      (found)
	);

	always #2 clk = ~clk;

	// Trial division over odd divisors up to the square root
	function automatic bit is_prime(input int unsigned v);
		int unsigned d;
		bit ok;
		if (v <= 1) begin
			return 1'b0;
		end
		if (v == 2) begin
			return 1'b1;
		end
		if (v[0] == 1'b0) begin
			return 1'b0;
		end
		ok = 1'b1;
		for (d = 3; ok && d * d <= v; d += 2) begin
			if (v % d == 0) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	// Smallest odd prime pair of the number, 2+2 for four, else the default pair
	function automatic pair_t goldbach_split(input logic [VALUE_WIDTH-1:0] v);
		pair_t p;
		int unsigned n;
		int unsigned c;
		n = v;
		p.low  = LOW_WIDTH'(2);
		p.high = VALUE_WIDTH'(2);
		p.fnd  = 1'b0;
		if (n == 4) begin
			p.fnd = 1'b1;
		end else begin
			for (c = 3; !p.fnd && c <= n / 2; c += 2) begin
				if (is_prime(c) && is_prime(n - c)) begin
					p.low  = LOW_WIDTH'(c);
					p.high = VALUE_WIDTH'(n - c);
					p.fnd  = 1'b1;
				end
			end
		end
		return p;
	endfunction

	function automatic int send_gap_pct(input phase_t p);
		case (p)
			PH_SEND_IDLE: return 83;
			PH_BOTH:      return 23;
			default:      return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(input phase_t p);
		case (p)
			PH_RECV_STALL: return 83;
			PH_BOTH:       return 23;
			default:       return 0;
		endcase
	endfunction

	// Mostly even numbers of random bit length, some small odd ones, some tiny noise; only small even numbers when tiny
	function automatic row_t random_number(input bit tiny);
		row_t r;
		int   sel;
		int   nb;
		r = '0;
		sel = $urandom_range(0, 99);
		if (tiny) begin
			r.value = VALUE_WIDTH'($urandom_range(2, 100) * 2);
		end else if (sel < 75) begin
			nb = $urandom_range(3, VALUE_WIDTH);
			r.value = VALUE_WIDTH'($urandom & ((32'd1 << nb) - 1));
			r.value[0] = 1'b0;
			if (r.value < 4) begin
				r.value = r.value + VALUE_WIDTH'(4);
			end
		end else if (sel < 90) begin
			r.value = VALUE_WIDTH'($urandom_range(0, 511) | 1);
		end else begin
			r.value = VALUE_WIDTH'($urandom_range(0, 15));
		end
		return r;
	endfunction

	// Offer numbers; log the expected pair of each accepted word
	always @(posedge clk) begin
		if (req_valid && !req_stall) begin
			if (offered.typed) begin
				pending_pairs.push_back('{offered.low, offered.high, offered.fnd});
			end else begin
				pending_pairs.push_back(goldbach_split(offered.value));
			end
		end
		if (!req_valid || !req_stall) begin
			if (numbers_q.size() > 0 && $urandom_range(0, 99) >= send_gap_pct(phase)) begin
				offered = numbers_q.pop_front();
				req_valid <= 1'b1;
				even_value <= offered.value;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Check each result word against the oldest expected pair
	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			if (pending_pairs.size() == 0) begin
				if (fails < 10) begin
					$display("result word %0d with nothing pending: low %0d high %0d found %0d",
						words_out, prime_low, prime_high, found);
				end
				fails++;
			end else begin
				want = pending_pairs.pop_front();
				if (prime_low !== want.low || prime_high !== want.high || found !== want.fnd) begin
					if (fails < 10) begin
						$display("word %0d: expected %0d+%0d found %0d, got %0d+%0d found %0d",
							words_out, want.low, want.high, want.fnd,
							prime_low, prime_high, found);
					end
					fails++;
				end
			end
			words_out++;
		end
	end

	// Drive stall; hold off for one long stretch in the pressure phase
	always @(posedge clk) begin
		if (phase == PH_HOLD && !hold_done) begin
			res_stall <= 1'b1;
			if (hold_cnt == HOLD_CYCLES - 1) begin
				hold_done <= 1'b1;
			end
			hold_cnt <= hold_cnt + 1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_stall_pct(phase));
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("goldbach_prime_pair_finder regression: fail");
			$finish;
		end
	end

	task automatic wait_drained();
		while (numbers_q.size() > 0 || req_valid || pending_pairs.size() > 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_random(input phase_t p, input int n_items);
		phase = p;
		for (int i = 0; i < n_items; i++) begin
			numbers_q.push_back(random_number(p == PH_HOLD));
		end
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// walk the directed table without idling
		phase = PH_DIRECTED;
		for (int i = 0; i < DIR_ROWS; i++) begin
			numbers_q.push_back(DIR_TAB[i]);
		end
		wait_drained();

		run_random(PH_FREE, 16);
		run_random(PH_SEND_IDLE, 16);
		run_random(PH_RECV_STALL, 16);
		run_random(PH_BOTH, 16);
		run_random(PH_HOLD, 16);
		phase = PH_FREE;
		run_random(PH_FREE, 20);

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fails == 0 && pending_pairs.size() == 0) begin
			$display("goldbach_prime_pair_finder regression: pass");
		end else begin
			$display("goldbach_prime_pair_finder regression: fail");
		end
		$finish;
	end

endmodule
